/* design/hkbd_pkg.sv */
// ----------------------------------------------------------------------------
// hkbd_pkg - shared constants and types for the keyboard report differ
// Field widths of the boot-protocol report and the event beat.
// ----------------------------------------------------------------------------
package hkbd_pkg;

    localparam int CODE_W         = 8;
    localparam int MOD_COUNT      = 8;
    localparam int INPUT_SLOTS    = 6;
    localparam int REPORT_W       = CODE_W * (1 + INPUT_SLOTS);
    localparam logic [CODE_W-1:0] MOD_USAGE_BASE = 8'hE0;
    localparam logic [CODE_W-1:0] EMPTY_CODE     = 8'h00;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              press;
        logic              last;
    } event_t;

endpackage

/* design/hkbd_front.sv */
// ----------------------------------------------------------------------------
// hkbd_front - report intake and change classification
// Compares each report with the stored one, builds the event mask and
// pushes reports that cause events into the queue.
// ----------------------------------------------------------------------------
module hkbd_front #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hkbd_pkg::REPORT_W-1:0] s_tdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [hkbd_pkg::MOD_COUNT + 2*KEY_SLOTS + hkbd_pkg::CODE_W*(1 + 2*KEY_SLOTS) - 1:0]
                                          push_data
);

    localparam int CW     = hkbd_pkg::CODE_W;
    localparam int MW     = hkbd_pkg::MOD_COUNT;
    localparam int MASK_W = MW + 2*KEY_SLOTS;

    logic [MW-1:0]           prev_mods_reg;
    logic [KEY_SLOTS*CW-1:0] prev_slots_reg;
    logic [MW-1:0]           new_mods;
    logic [KEY_SLOTS*CW-1:0] new_slots;
    logic [KEY_SLOTS-1:0]    rel_bits;
    logic [KEY_SLOTS-1:0]    prs_bits;
    logic [MASK_W-1:0]       mask;
    logic                    accept;

    assign new_mods = s_tdata[MW-1:0];

    // slots beyond the report read as empty
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
        if (g < hkbd_pkg::INPUT_SLOTS) begin : g_in
            assign new_slots[g*CW +: CW] = s_tdata[CW + g*CW +: CW];
        end else begin : g_pad
            assign new_slots[g*CW +: CW] = hkbd_pkg::EMPTY_CODE;
        end
    end

    always_comb begin
        logic in_new;
        logic in_prev;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            in_new  = 1'b0;
            in_prev = 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (new_slots[i*CW +: CW] == prev_slots_reg[j*CW +: CW]) begin
                    in_new = 1'b1;
                end
                if (prev_slots_reg[i*CW +: CW] == new_slots[j*CW +: CW]) begin
                    in_prev = 1'b1;
                end
            end
            rel_bits[j] = (prev_slots_reg[j*CW +: CW] != hkbd_pkg::EMPTY_CODE) && !in_new;
            prs_bits[j] = (new_slots[j*CW +: CW] != hkbd_pkg::EMPTY_CODE) && !in_prev;
        end
    end

    assign mask       = {prs_bits, rel_bits, prev_mods_reg ^ new_mods};
    assign s_tready   = push_ready;
    assign accept     = s_tvalid && s_tready;
    // drop reports that change nothing
    assign push_valid = accept && (mask != '0);
    assign push_data  = {new_slots, prev_slots_reg, new_mods, mask};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mods_reg  <= '0;
            prev_slots_reg <= '0;
        end else if (accept) begin
            prev_mods_reg  <= new_mods;
            prev_slots_reg <= new_slots;
        end
    end

endmodule

/* design/hkbd_fifo.sv */
// ----------------------------------------------------------------------------
// hkbd_fifo - two-entry queue between intake and event emission
// Lets the intake keep taking reports while events are still going out.
// ----------------------------------------------------------------------------
module hkbd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0]           mem_reg [DEPTH];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [$clog2(DEPTH+1)-1:0] count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != DEPTH[$clog2(DEPTH+1)-1:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/hkbd_back.sv */
// ----------------------------------------------------------------------------
// hkbd_back - event emitter
// Walks the event mask of the current report, lowest bit first, and
// emits one event per cycle into the output register unless it is stalled.
// ----------------------------------------------------------------------------
module hkbd_back #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [hkbd_pkg::MOD_COUNT + 2*KEY_SLOTS + hkbd_pkg::CODE_W*(1 + 2*KEY_SLOTS) - 1:0]
                                 pop_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output hkbd_pkg::event_t     m_event
);

    localparam int CW     = hkbd_pkg::CODE_W;
    localparam int MW     = hkbd_pkg::MOD_COUNT;
    localparam int MASK_W = MW + 2*KEY_SLOTS;

    logic [MASK_W-1:0]       cur_mask_reg;
    logic [MW-1:0]           cur_mods_reg;
    logic [KEY_SLOTS*CW-1:0] cur_prev_reg;
    logic [KEY_SLOTS*CW-1:0] cur_new_reg;
    logic                    m_tvalid_reg;
    hkbd_pkg::event_t        event_reg;

    logic [MASK_W-1:0] pick;
    logic [MASK_W-1:0] rest_mask;
    logic [CW-1:0]     pick_code;
    logic              pick_press;
    logic              busy;
    logic              out_en;
    logic              emit;
    logic              last;

    // lowest set bit wins: scan from the back of the order toward the front
    always_comb begin
        pick       = '0;
        pick_code  = hkbd_pkg::EMPTY_CODE;
        pick_press = 1'b0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (cur_mask_reg[MW + KEY_SLOTS + i]) begin
                pick       = '0;
                pick[MW + KEY_SLOTS + i] = 1'b1;
                pick_code  = cur_new_reg[i*CW +: CW];
                pick_press = 1'b1;
            end
        end
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (cur_mask_reg[MW + i]) begin
                pick       = '0;
                pick[MW + i] = 1'b1;
                pick_code  = cur_prev_reg[i*CW +: CW];
                pick_press = 1'b0;
            end
        end
        for (int i = MW - 1; i >= 0; i--) begin
            if (cur_mask_reg[i]) begin
                pick       = '0;
                pick[i]    = 1'b1;
                pick_code  = hkbd_pkg::MOD_USAGE_BASE | CW'(i);
                pick_press = cur_mods_reg[i];
            end
        end
    end

    assign rest_mask = cur_mask_reg & ~pick;
    assign busy      = (cur_mask_reg != '0);
    assign out_en    = !m_tvalid_reg || m_tready;
    assign emit      = busy && out_en;
    assign last      = (rest_mask == '0);
    // refill as the last event of the current report goes out
    assign pop_ready = !busy || (emit && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mask_reg <= '0;
        end else if (pop_valid && pop_ready) begin
            cur_mask_reg <= pop_data[MASK_W-1:0];
        end else if (emit) begin
            cur_mask_reg <= rest_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            {cur_new_reg, cur_prev_reg, cur_mods_reg} <= pop_data[$bits(pop_data)-1:MASK_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= busy;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            event_reg.code  <= pick_code;
            event_reg.press <= pick_press;
            event_reg.last  <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_event  = event_reg;

endmodule

/* design/hid_keyboard_report_to_key_events.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events - boot keyboard report to key events
// Turns each report into press/release events against the previous report.
// ----------------------------------------------------------------------------
// A report is taken in one beat and compared at once with the stored report;
// the stored report is replaced on every accepted beat. Reports that cause
// events wait in a two-report queue; the emitter sends one event per cycle
// while m_tready allows; a report with N events (N up to 8 + 2*KEY_SLOTS,
// 20 by default) gives N event beats, and a report with no change is not
// queued. The input side keeps taking one report per cycle as long as
// the queue has room; the output is registered and moves one beat per cycle
// while m_tready is high. Events come out as modifiers 0xE0..0xE7 first, then
// releases in slot order, then presses in slot order, with tlast on the last.
module hid_keyboard_report_to_key_events #(
    parameter int KEY_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // modifier_bits, slot0_code .. slot5_code (8 bits each, from bit 0 up)
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_code
    output logic [7:0]  m_tdata,
    // is_press
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int ENTRY_W = hkbd_pkg::MOD_COUNT + 2*KEY_SLOTS
                           + hkbd_pkg::CODE_W*(1 + 2*KEY_SLOTS);

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    hkbd_pkg::event_t   m_event;

    hkbd_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hkbd_fifo #(.WIDTH(ENTRY_W)) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hkbd_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_event   (m_event)
    );

    assign m_tdata = m_event.code;
    assign m_tuser = m_event.press;
    assign m_tlast = m_event.last;

endmodule

/* design/hkbd_checker.sv */
// ----------------------------------------------------------------------------
// hkbd_checker - port-level checks for the keyboard report differ
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module hkbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // hold a stalled report beat
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("stalled report beat changed");

    // hold a stalled event beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled event beat changed");

    // an empty slot code never turns into an event
    a_code_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 8'h00)
        else $error("event with empty key code");

    // reset drops any pending event
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("event beat valid right after reset");

    // a valid event beat carries known values
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser, m_tlast}))
        else $error("event beat carries unknown bits");

endmodule

bind hid_keyboard_report_to_key_events hkbd_checker u_hkbd_checker (.*);

/* verif/hid_keyboard_report_to_key_events_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events_tb - key event stream check
// Feeds boot keyboard reports through the input stream, predicts the press and
// release events of each accepted report from the stored previous report, and
// compares every event beat in order. Both sides idle at random by phase.
// ----------------------------------------------------------------------------

typedef logic [hkbd_pkg::CODE_W-1:0] slot_set_t [hkbd_pkg::INPUT_SLOTS];

class key_event_scoreboard;
    logic [hkbd_pkg::CODE_W-1:0] held_mods;
    slot_set_t                   held_slots;
    hkbd_pkg::event_t            pending_events[$];
    int                          mismatches;

    function new();
        held_mods = '0;
        foreach (held_slots[i]) held_slots[i] = hkbd_pkg::EMPTY_CODE;
        mismatches = 0;
    endfunction

    function int pending_count();
        return pending_events.size();
    endfunction

    function bit slots_hold(slot_set_t slots, logic [hkbd_pkg::CODE_W-1:0] code);
        foreach (slots[i])
            if (slots[i] == code) return 1'b1;
        return 1'b0;
    endfunction

    // Diff one accepted report against the held one, then replace it.
    function void note_report(logic [hkbd_pkg::REPORT_W-1:0] beat);
        logic [hkbd_pkg::CODE_W-1:0] mods;
        logic [hkbd_pkg::CODE_W-1:0] released;
        logic [hkbd_pkg::CODE_W-1:0] pressed;
        slot_set_t                   slots;
        hkbd_pkg::event_t            fresh[$];
        hkbd_pkg::event_t            ev;
        mods = beat[hkbd_pkg::CODE_W-1:0];
        foreach (slots[i]) slots[i] = beat[hkbd_pkg::CODE_W*(i+1) +: hkbd_pkg::CODE_W];
        released = held_mods & ~mods;
        pressed  = mods & ~held_mods;
        ev.last = 1'b0;
        for (int b = 0; b < hkbd_pkg::MOD_COUNT; b++) begin
            ev.code = hkbd_pkg::MOD_USAGE_BASE + hkbd_pkg::CODE_W'(b);
            if (released[b]) begin
                ev.press = 1'b0;
                fresh.push_back(ev);
            end
            if (pressed[b]) begin
                ev.press = 1'b1;
                fresh.push_back(ev);
            end
        end
        foreach (held_slots[i]) begin
            if (held_slots[i] != hkbd_pkg::EMPTY_CODE
                && !slots_hold(slots, held_slots[i])) begin
                ev.code  = held_slots[i];
                ev.press = 1'b0;
                fresh.push_back(ev);
            end
        end
        foreach (slots[i]) begin
            if (slots[i] != hkbd_pkg::EMPTY_CODE && !slots_hold(held_slots, slots[i])) begin
                ev.code  = slots[i];
                ev.press = 1'b1;
                fresh.push_back(ev);
            end
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
        foreach (fresh[i]) pending_events.push_back(fresh[i]);
        held_mods  = mods;
        held_slots = slots;
    endfunction

    function void check_event(logic [hkbd_pkg::CODE_W-1:0] code, logic press, logic last);
        hkbd_pkg::event_t want;
        if (pending_events.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected event: code=%h press=%b last=%b", code, press, last);
            mismatches++;
            return;
        end
        want = pending_events.pop_front();
        if (code !== want.code || press !== want.press || last !== want.last) begin
            if (mismatches < 10)
                $display({"event mismatch: expected code=%h press=%b last=%b,",
                          " got code=%h press=%b last=%b"},
                         want.code, want.press, want.last, code, press, last);
            mismatches++;
        end
    endfunction
endclass

module hid_keyboard_report_to_key_events_tb;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // modifier_bits, slot0_code .. slot5_code (8 bits each, from bit 0 up)
    logic [hkbd_pkg::REPORT_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // event_code
    logic [7:0]                    m_tdata;
    // is_press
    logic                          m_tuser;
    logic                          m_tlast;

    key_event_scoreboard           sb = new();
    int                            sender_idle_pct = 0;
    int                            receiver_stall_pct = 0;
    logic [hkbd_pkg::REPORT_W-1:0] last_report = '0;

    hid_keyboard_report_to_key_events u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_report(s_tdata);
            if (m_tvalid && m_tready) sb.check_event(m_tdata, m_tuser, m_tlast);
        end
    end

    function automatic logic [hkbd_pkg::REPORT_W-1:0] pack_report(
        logic [7:0] mods, logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
        logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
        return {k5, k4, k3, k2, k1, k0, mods};
    endfunction

    // Mostly evolve the last report like real typing; sometimes repeat it or
    // throw in a fully random one.
    function automatic logic [hkbd_pkg::REPORT_W-1:0] next_report(
        logic [hkbd_pkg::REPORT_W-1:0] prev);
        logic [hkbd_pkg::REPORT_W-1:0] rpt;
        int                            mode;
        rpt  = prev;
        mode = $urandom_range(9);
        if (mode == 0) return rpt;
        if (mode == 1) return hkbd_pkg::REPORT_W'({$urandom, $urandom});
        for (int b = 0; b < hkbd_pkg::MOD_COUNT; b++)
            if ($urandom_range(99) < 15) rpt[b] = ~rpt[b];
        for (int i = 1; i <= hkbd_pkg::INPUT_SLOTS; i++) begin
            if ($urandom_range(99) < 35) begin
                case ($urandom_range(4))
                    0: rpt[8*i +: 8] = hkbd_pkg::EMPTY_CODE;
                    1: rpt[8*i +: 8] = 8'($urandom_range(255));
                    2: rpt[8*i +: 8] = hkbd_pkg::MOD_USAGE_BASE + 8'($urandom_range(7));
                    default: rpt[8*i +: 8] = 8'($urandom_range(4, 11));
                endcase
            end
        end
        return rpt;
    endfunction

    task automatic send_report(input logic [hkbd_pkg::REPORT_W-1:0] rpt);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rpt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        last_report = rpt;
    endtask

    // Hold the input quiet until every predicted event has come out.
    task automatic drain_events();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_report(next_report(last_report));
        drain_events();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no change from the reset state
        send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'h55, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        // every modifier flips, all keys released and new ones pressed
        send_report(pack_report(8'hAA, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
        send_report(pack_report(8'h00, 8'hFF, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'h00));
        send_report(pack_report(8'h00, 8'hFF, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'h00));
        // reorder keys: only the missing and the new one report
        send_report(pack_report(8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h2C, 8'h01));
        // duplicate codes press and release once per slot
        send_report(pack_report(8'h00, 8'h1E, 8'h1E, 8'h1E, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'h00, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1E));
        send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'h00, 8'h21, 8'h21, 8'h22, 8'h22, 8'h21, 8'h22));
        send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // modifier usages in slots stay apart from the modifier byte
        send_report(pack_report(8'h00, 8'hE0, 8'hE1, 8'hE7, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'h81, 8'hE0, 8'hE1, 8'hE7, 8'h00, 8'h00, 8'h00));
        send_report(pack_report(8'h80, 8'h00, 8'hE1, 8'h00, 8'h00, 8'h00, 8'hE0));
        send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        drain_events();

        run_random(25, 0, 0);
        run_random(25, 71, 0);
        run_random(25, 0, 71);
        run_random(25, 22, 22);

        repeat (50) @(posedge aclk);
        if (sb.pending_count() != 0)
            $display("%0d expected events never came out", sb.pending_count());
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout waiting for key events");
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
design/hkbd_pkg.sv
design/hkbd_front.sv
design/hkbd_fifo.sv
design/hkbd_back.sv
design/hid_keyboard_report_to_key_events.sv
design/hkbd_checker.sv
verif/hid_keyboard_report_to_key_events_tb.sv
